### src/cdq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cdq_pkg
// Shared types, constants and index helpers of the circular deque unit.
// ----------------------------------------------------------------------------
package cdq_pkg;

  localparam int unsigned DEPTH  = 8;
  localparam int unsigned IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned FUNC_W = 3;
  localparam int unsigned STAT_W = 2;

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [DATA_W-1:0] data_t;

  typedef enum logic [FUNC_W-1:0] {
    FN_PUSH_FRONT = 3'd0,
    FN_PUSH_REAR  = 3'd1,
    FN_POP_FRONT  = 3'd2,
    FN_POP_REAR   = 3'd3,
    FN_QUERY      = 3'd4
  } func_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    RD_POP   = 2'd0,
    RD_FRONT = 2'd1,
    RD_REAR  = 2'd2
  } rd_sel_e;

  // controller to datapath commands
  typedef struct packed {
    logic    load;
    logic    exec;
    logic    cap_pop;
    logic    cap_front;
    rd_sel_e rd_sel;
  } cmd_t;

  function automatic idx_t idx_inc(idx_t i);
    return (i == IDX_W'(DEPTH - 1)) ? '0 : i + IDX_W'(1);
  endfunction

  function automatic idx_t idx_dec(idx_t i);
    return (i == '0) ? IDX_W'(DEPTH - 1) : i - IDX_W'(1);
  endfunction

endpackage
`default_nettype wire

### src/cdq_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cdq_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module cdq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 8
) (
  input  wire logic                                      clk_i,
  input  wire logic                                      we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                          wdata_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

### src/cdq_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cdq_ctrl
// Sequencer: execute the operation, then read popped, front and rear words.
// ----------------------------------------------------------------------------
module cdq_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  output logic               busy_o,
  output logic               done_o,
  output cdq_pkg::cmd_t      cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_OP   = 5'b00010,
    S_RDF  = 5'b00100,
    S_RDR  = 5'b01000,
    S_DONE = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign busy_o = (state_q != S_IDLE) && (state_q != S_DONE);
  assign done_o = (state_q == S_DONE);
  assign accept = start_i && !busy_o;

  always_comb begin
    state_d         = state_q;
    cmd_o           = '0;
    cmd_o.rd_sel    = cdq_pkg::RD_REAR;
    cmd_o.load      = accept;
    case (state_q)
      S_IDLE: begin
        if (accept) state_d = S_OP;
      end
      S_OP: begin
        cmd_o.exec   = 1'b1;
        cmd_o.rd_sel = cdq_pkg::RD_POP;
        state_d      = S_RDF;
      end
      S_RDF: begin
        cmd_o.cap_pop = 1'b1;
        cmd_o.rd_sel  = cdq_pkg::RD_FRONT;
        state_d       = S_RDR;
      end
      S_RDR: begin
        cmd_o.cap_front = 1'b1;
        cmd_o.rd_sel    = cdq_pkg::RD_REAR;
        state_d         = S_DONE;
      end
      S_DONE: begin
        state_d = accept ? S_OP : S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

### src/cdq_dpath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cdq_dpath
// Ring indices, ring store and result registers of the deque.
// ----------------------------------------------------------------------------
module cdq_dpath (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire cdq_pkg::cmd_t                        cmd_i,
  input  wire logic [cdq_pkg::FUNC_W-1:0]           func_i,
  input  wire logic signed [cdq_pkg::DATA_W-1:0]    push_value_i,
  output logic signed [cdq_pkg::DATA_W-1:0]         popped_value_o,
  output logic signed [cdq_pkg::DATA_W-1:0]         front_value_o,
  output logic signed [cdq_pkg::DATA_W-1:0]         rear_value_o,
  output logic                                      is_empty_o,
  output logic                                      is_full_o,
  output logic [cdq_pkg::STAT_W-1:0]                status_o
);

  logic [cdq_pkg::FUNC_W-1:0] func_q;
  cdq_pkg::data_t             push_value_q;
  cdq_pkg::idx_t              front_idx_q, front_idx_d;
  cdq_pkg::idx_t              rear_idx_q, rear_idx_d;
  cdq_pkg::status_e           status_q, status_d;
  logic                       pop_ok_q, pop_ok_d;
  cdq_pkg::data_t             popped_q, front_val_q;

  logic                       we;
  cdq_pkg::idx_t              waddr, raddr;
  cdq_pkg::data_t             rdata;
  logic                       empty, full;

  assign empty = (front_idx_q == rear_idx_q);
  assign full  = (cdq_pkg::idx_inc(rear_idx_q) == front_idx_q);

  always_comb begin
    front_idx_d = front_idx_q;
    rear_idx_d  = rear_idx_q;
    status_d    = status_q;
    pop_ok_d    = pop_ok_q;
    we          = 1'b0;
    waddr       = front_idx_q;
    if (cmd_i.exec) begin
      status_d = cdq_pkg::ST_OK;
      pop_ok_d = 1'b0;
      case (cdq_pkg::func_e'(func_q))
        cdq_pkg::FN_PUSH_FRONT: begin
          if (full) begin
            status_d = cdq_pkg::ST_FULL;
          end else begin
            we          = 1'b1;
            front_idx_d = cdq_pkg::idx_dec(front_idx_q);
          end
        end
        cdq_pkg::FN_PUSH_REAR: begin
          waddr = cdq_pkg::idx_inc(rear_idx_q);
          if (full) begin
            status_d = cdq_pkg::ST_FULL;
          end else begin
            we         = 1'b1;
            rear_idx_d = cdq_pkg::idx_inc(rear_idx_q);
          end
        end
        cdq_pkg::FN_POP_FRONT: begin
          if (empty) begin
            status_d = cdq_pkg::ST_EMPTY;
          end else begin
            pop_ok_d    = 1'b1;
            front_idx_d = cdq_pkg::idx_inc(front_idx_q);
          end
        end
        cdq_pkg::FN_POP_REAR: begin
          if (empty) begin
            status_d = cdq_pkg::ST_EMPTY;
          end else begin
            pop_ok_d   = 1'b1;
            rear_idx_d = cdq_pkg::idx_dec(rear_idx_q);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // pop address uses the indices before the update of the same cycle
  always_comb begin
    case (cmd_i.rd_sel)
      cdq_pkg::RD_POP: begin
        raddr = (cdq_pkg::func_e'(func_q) == cdq_pkg::FN_POP_FRONT) ?
                cdq_pkg::idx_inc(front_idx_q) : rear_idx_q;
      end
      cdq_pkg::RD_FRONT: raddr = cdq_pkg::idx_inc(front_idx_q);
      default:           raddr = rear_idx_q;
    endcase
  end

  cdq_ram #(
    .WIDTH (cdq_pkg::DATA_W),
    .DEPTH (cdq_pkg::DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (push_value_q),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_idx_q <= '0;
      rear_idx_q  <= '0;
      status_q    <= cdq_pkg::ST_OK;
      pop_ok_q    <= 1'b0;
    end else begin
      front_idx_q <= front_idx_d;
      rear_idx_q  <= rear_idx_d;
      status_q    <= status_d;
      pop_ok_q    <= pop_ok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q       <= func_i;
      push_value_q <= push_value_i;
    end
    if (cmd_i.cap_pop) begin
      popped_q <= pop_ok_q ? rdata : '0;
    end
    if (cmd_i.cap_front) begin
      front_val_q <= rdata;
    end
  end

  // rear word arrives from the ram in the result cycle
  assign popped_value_o = popped_q;
  assign front_value_o  = empty ? '0 : front_val_q;
  assign rear_value_o   = empty ? '0 : rdata;
  assign is_empty_o     = empty;
  assign is_full_o      = full;
  assign status_o       = status_q;

endmodule
`default_nettype wire

### src/circular_deque_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// circular_deque_unit
// Double-ended queue of 32-bit words held in a ring with one spare slot.
// ----------------------------------------------------------------------------
// Usage:
//   An operation beat is taken at a rising edge with start_i high and busy_o
//   low. func_i selects push front, push rear, pop front, pop rear or query;
//   push_value_i is the word written by a push.
//   done_o rises once the sequencer has passed through its execute,
//   front-read and rear-read states, and is high for exactly one cycle.
//   In that cycle the result ports carry the popped word, the front and
//   rear words, the empty and full flags and the status. The receiver has
//   no way to stall: a result beat is taken at the edge that ends the
//   done_o cycle. busy_o is low in the done_o cycle, so a new beat may be
//   taken there. Operations do not overlap, as the ring store has a single
//   read port: the popped word is read in the cycle that updates the
//   indices, from the indices before the update, then the front and rear
//   words one after the other. A push on a full deque or a pop on an empty
//   one changes nothing and reports an error status. Reset clears both
//   indices, giving an empty deque; the store itself needs no clearing.
// ----------------------------------------------------------------------------
module circular_deque_unit (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 start_i,
  output logic                                      busy_o,
  input  wire logic [cdq_pkg::FUNC_W-1:0]           func_i,
  input  wire logic signed [cdq_pkg::DATA_W-1:0]    push_value_i,
  output logic                                      done_o,
  output logic signed [cdq_pkg::DATA_W-1:0]         popped_value_o,
  output logic signed [cdq_pkg::DATA_W-1:0]         front_value_o,
  output logic signed [cdq_pkg::DATA_W-1:0]         rear_value_o,
  output logic                                      is_empty_o,
  output logic                                      is_full_o,
  output logic [cdq_pkg::STAT_W-1:0]                status_o
);

  cdq_pkg::cmd_t cmd;

  cdq_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .done_o  (done_o),
    .cmd_o   (cmd)
  );

  cdq_dpath u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .func_i         (func_i),
    .push_value_i   (push_value_i),
    .popped_value_o (popped_value_o),
    .front_value_o  (front_value_o),
    .rear_value_o   (rear_value_o),
    .is_empty_o     (is_empty_o),
    .is_full_o      (is_full_o),
    .status_o       (status_o)
  );

  // result strobe never stays high in back-to-back cycles
  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("done_o held for more than one cycle");

  // an accepted beat keeps the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("accepted beat did not raise busy_o");

  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !(is_empty_o && is_full_o))
    else $error("deque reported empty and full at once");

  // a refused pop returns zero
  a_refused_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o == cdq_pkg::ST_EMPTY)) |-> (popped_value_o == '0))
    else $error("refused pop returned a nonzero word");

endmodule
`default_nettype wire
